/* sv/assert_macros.svh */
// Assertion macros for the port-level checker of the epoch-to-calendar block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while in reset.
`define E2C_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, muted while in reset.
`define E2C_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/e2c_pkg.sv */
// Constants, widths and the month table of the epoch-to-calendar block.
package e2c_pkg;

	localparam int EpochW = 32;
	localparam int SecW   = 6;
	localparam int MinW   = 6;
	localparam int HourW  = 5;
	localparam int DayW   = 5;
	localparam int MonW   = 4;
	localparam int YearW  = 12;
	localparam int FatW   = 32;
	localparam int DoyW   = 9;   // day of year, 0..365

	// Reciprocal multipliers: x/15 = (x*M15)>>35, x/3 = (x*M3)>>33 for 32-bit x
	localparam logic [31:0] DivBy15Magic = 32'h8888_8889;
	localparam logic [31:0] DivBy3Magic  = 32'hAAAA_AAAB;
	// days/1461 = (days*M)>>26, exact for days below 94519
	localparam logic [15:0] DivBy1461Magic = 16'd45934;

	localparam int DaysPerCycle = 1461;
	localparam int YearLen      = 365;
	localparam int LeapLen      = 366;
	localparam int BaseYear     = 1970;
	localparam int FatBaseYear  = 1980;

	localparam logic [10:0] Yr1Start = 11'(YearLen);
	localparam logic [10:0] Yr2Start = 11'(2 * YearLen);
	localparam logic [10:0] Yr3Start = 11'(2 * YearLen + LeapLen);

	// First day of year (0-based) of month index m0 (0 = January)
	function automatic logic [DoyW-1:0] month_start(input logic [MonW-1:0] m0,
		input logic leap);
		logic [DoyW-1:0] base;
		case (m0)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && m0 >= 4'd2) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

/* sv/e2c_epoch_if.sv */
// Valid/ready channel carrying one epoch-seconds timestamp.
interface e2c_epoch_if;
	import e2c_pkg::*;

	logic              valid;
	logic              ready;
	logic [EpochW-1:0] epoch_seconds;

	modport source(output valid, output epoch_seconds, input ready);
	modport sink(input valid, input epoch_seconds, output ready);
endinterface

/* sv/e2c_cal_if.sv */
// Valid/ready channel carrying one calendar date and FAT date-time result.
interface e2c_cal_if;
	import e2c_pkg::*;

	logic             valid;
	logic             ready;
	logic [SecW-1:0]  second_of_minute;
	logic [MinW-1:0]  minute_of_hour;
	logic [HourW-1:0] hour_of_day;
	logic [DayW-1:0]  day_of_month;
	logic [MonW-1:0]  month_of_year;
	logic [YearW-1:0] calendar_year;
	logic [FatW-1:0]  fat_word;
	logic             fat_status;

	modport source(output valid, output second_of_minute, output minute_of_hour,
		output hour_of_day, output day_of_month, output month_of_year,
		output calendar_year, output fat_word, output fat_status, input ready);
	modport sink(input valid, input second_of_minute, input minute_of_hour,
		input hour_of_day, input day_of_month, input month_of_year,
		input calendar_year, input fat_word, input fat_status, output ready);
endinterface

/* sv/epoch_seconds_to_calendar_and_fat_top.sv */
// Epoch seconds to calendar date and FAT date-time word, seven-stage pipeline.
//
//  channel | dir | payload                                  | transfer when
//  --------+-----+------------------------------------------+----------------------
//  ts      | in  | epoch_seconds[31:0]                      | ts.valid & ts.ready
//  cal     | out | sec,min,hour,day,month,year,fat word/flag | cal.valid & cal.ready
//
//  A transfer passes stages s1 to s7 in turn; one timestamp per cycle unless cal stalls.
//  Depth is set by the chain of reciprocal multiplies (/60, /60, /24, /1461),
//  each followed by a register, then year, month and FAT packing stages.
//  arst_n clears the stage valid bits only; data registers are not reset.
//  A stage loads when it is empty or the stage after it moves, so bubbles
//  close up while cal is stalled and nothing is dropped or repeated.
module epoch_seconds_to_calendar_and_fat_top (
	input logic clk,
	input logic arst_n,
	e2c_epoch_if.sink ts,
	e2c_cal_if.source cal
);
	import e2c_pkg::*;

	// Per-stage valid bits and load enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;

	assign adv_s7 = !vld_s7 || cal.ready;
	assign adv_s6 = !vld_s6 || adv_s7;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign ts.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= ts.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
		end
	end

	// ---- Stage 1: total minutes = t/60 = (t>>2)/15 -------------------------
	logic [61:0] min_prod_c;
	logic [EpochW-1:0] t_s1;
	logic [26:0] qmin_s1;

	assign min_prod_c = 62'(ts.epoch_seconds[EpochW-1:2]) * 62'(DivBy15Magic);

	always_ff @(posedge clk) begin
		if (adv_s1 && ts.valid) begin
			t_s1    <= ts.epoch_seconds;
			qmin_s1 <= min_prod_c[61:35];
		end
	end

	// ---- Stage 2: seconds remainder, total hours = minutes/60 ---------------
	logic [32:0] qmin60_c;
	logic [56:0] hr_prod_c;
	logic [SecW-1:0] sec_s2;
	logic [5:0] qmin_lo_s2;
	logic [20:0] qhr_s2;

	// Remainder is below 64, so only the low bits of the subtraction matter
	assign qmin60_c  = {qmin_s1, 6'b0} - {4'b0, qmin_s1, 2'b0};
	assign hr_prod_c = 57'(qmin_s1[26:2]) * 57'(DivBy15Magic);

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			sec_s2     <= t_s1[5:0] - qmin60_c[5:0];
			qmin_lo_s2 <= qmin_s1[5:0];
			qhr_s2     <= hr_prod_c[55:35];
		end
	end

	// ---- Stage 3: minutes remainder, days = hours/24 = (hours>>3)/3 ---------
	logic [49:0] day_prod_c;
	logic [SecW-1:0] sec_s3;
	logic [MinW-1:0] min_s3;
	logic [4:0] qhr_lo_s3;
	logic [15:0] days_s3;

	assign day_prod_c = 50'(qhr_s2[20:3]) * 50'(DivBy3Magic);

	always_ff @(posedge clk) begin
		if (adv_s3 && vld_s2) begin
			sec_s3    <= sec_s2;
			min_s3    <= qmin_lo_s2 - {qhr_s2[3:0], 2'b0} * 6'd15;
			qhr_lo_s3 <= qhr_s2[4:0];
			days_s3   <= day_prod_c[48:33];
		end
	end

	// ---- Stage 4: hours remainder, four-year cycle = days/1461 --------------
	logic [31:0] cyc_prod_c;
	logic [SecW-1:0] sec_s4;
	logic [MinW-1:0] min_s4;
	logic [HourW-1:0] hr_s4;
	logic [15:0] days_s4;
	logic [5:0] cyc_s4;

	assign cyc_prod_c = 32'(days_s3) * 32'(DivBy1461Magic);

	always_ff @(posedge clk) begin
		if (adv_s4 && vld_s3) begin
			sec_s4  <= sec_s3;
			min_s4  <= min_s3;
			// days*24 = days*16 + days*8, low five bits
			hr_s4   <= qhr_lo_s3 - ({days_s3[0], 4'b0} + {days_s3[1:0], 3'b0});
			days_s4 <= days_s3;
			cyc_s4  <= cyc_prod_c[31:26];
		end
	end

	// ---- Stage 5: year within the cycle (365, 365, 366, 365) ----------------
	logic [16:0] cyc_days_c;
	logic [16:0] doc_full_c;
	logic [10:0] doc_c;
	logic [1:0] yoff_c;
	logic [10:0] doy_c;
	logic leap_c;
	logic [SecW-1:0] sec_s5;
	logic [MinW-1:0] min_s5;
	logic [HourW-1:0] hr_s5;
	logic [YearW-1:0] year_s5;
	logic [DoyW-1:0] doy_s5;
	logic leap_s5;

	assign cyc_days_c = 17'(cyc_s4) * 17'(DaysPerCycle);
	assign doc_full_c = {1'b0, days_s4} - cyc_days_c;
	assign doc_c      = doc_full_c[10:0];

	always_comb begin
		if (doc_c < Yr1Start) begin
			yoff_c = 2'd0;
			doy_c  = doc_c;
			leap_c = 1'b0;
		end else if (doc_c < Yr2Start) begin
			yoff_c = 2'd1;
			doy_c  = doc_c - Yr1Start;
			leap_c = 1'b0;
		end else if (doc_c < Yr3Start) begin
			yoff_c = 2'd2;
			doy_c  = doc_c - Yr2Start;
			leap_c = 1'b1;
		end else begin
			yoff_c = 2'd3;
			doy_c  = doc_c - Yr3Start;
			leap_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && vld_s4) begin
			sec_s5  <= sec_s4;
			min_s5  <= min_s4;
			hr_s5   <= hr_s4;
			year_s5 <= 12'(BaseYear) + {4'b0, cyc_s4, 2'b0} + {10'b0, yoff_c};
			doy_s5  <= doy_c[DoyW-1:0];
			leap_s5 <= leap_c;
		end
	end

	// ---- Stage 6: month and day from the month-start table ------------------
	logic [MonW-1:0] mon_idx_c;
	logic [DoyW-1:0] dom0_c;
	logic [SecW-1:0] sec_s6;
	logic [MinW-1:0] min_s6;
	logic [HourW-1:0] hr_s6;
	logic [YearW-1:0] year_s6;
	logic [MonW-1:0] mon_s6;
	logic [DayW-1:0] day_s6;

	// Starts are increasing, so the last one passed is the month
	always_comb begin
		mon_idx_c = '0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s5 >= month_start(MonW'(i), leap_s5)) begin
				mon_idx_c = MonW'(i);
			end
		end
	end

	assign dom0_c = doy_s5 - month_start(mon_idx_c, leap_s5);

	always_ff @(posedge clk) begin
		if (adv_s6 && vld_s5) begin
			sec_s6  <= sec_s5;
			min_s6  <= min_s5;
			hr_s6   <= hr_s5;
			year_s6 <= year_s5;
			mon_s6  <= mon_idx_c + 4'd1;
			day_s6  <= dom0_c[DayW-1:0] + 5'd1;
		end
	end

	// ---- Stage 7: FAT packing, output register ------------------------------
	logic fat_pre_c;
	logic [YearW-1:0] fat_yr_c;
	logic [FatW-1:0] fat_c;
	logic [SecW-1:0] sec_s7;
	logic [MinW-1:0] min_s7;
	logic [HourW-1:0] hr_s7;
	logic [YearW-1:0] year_s7;
	logic [MonW-1:0] mon_s7;
	logic [DayW-1:0] day_s7;
	logic [FatW-1:0] fat_s7;
	logic stat_s7;

	assign fat_pre_c = year_s6 < 12'(FatBaseYear);
	assign fat_yr_c  = year_s6 - 12'(FatBaseYear);
	assign fat_c     = fat_pre_c ? '0 :
		{fat_yr_c[6:0], mon_s6, day_s6, hr_s6, min_s6, sec_s6[5:1]};

	always_ff @(posedge clk) begin
		if (adv_s7 && vld_s6) begin
			sec_s7  <= sec_s6;
			min_s7  <= min_s6;
			hr_s7   <= hr_s6;
			year_s7 <= year_s6;
			mon_s7  <= mon_s6;
			day_s7  <= day_s6;
			fat_s7  <= fat_c;
			stat_s7 <= fat_pre_c;
		end
	end

	assign cal.valid            = vld_s7;
	assign cal.second_of_minute = sec_s7;
	assign cal.minute_of_hour   = min_s7;
	assign cal.hour_of_day      = hr_s7;
	assign cal.day_of_month     = day_s7;
	assign cal.month_of_year    = mon_s7;
	assign cal.calendar_year    = year_s7;
	assign cal.fat_word         = fat_s7;
	assign cal.fat_status       = stat_s7;

endmodule

/* sv/e2c_checker.sv */
// Port-level checks of the epoch-to-calendar block and their bind.
`include "assert_macros.svh"

module e2c_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cal_valid,
	input logic                      cal_ready,
	input logic [e2c_pkg::SecW-1:0]  cal_sec,
	input logic [e2c_pkg::MinW-1:0]  cal_min,
	input logic [e2c_pkg::HourW-1:0] cal_hour,
	input logic [e2c_pkg::DayW-1:0]  cal_day,
	input logic [e2c_pkg::MonW-1:0]  cal_month,
	input logic [e2c_pkg::YearW-1:0] cal_year,
	input logic [e2c_pkg::FatW-1:0]  cal_fat,
	input logic                      cal_stat
);
	import e2c_pkg::*;

	// Stalled result holds valid, fat word, year and seconds
	`E2C_ASSERT_NXT(a_cal_hold, cal_valid && !cal_ready, cal_valid && $stable(cal_fat) && $stable(cal_year) && $stable(cal_sec), "cal payload changed while stalled")

	// Status flag follows the year
	`E2C_ASSERT(a_stat_year, cal_valid, cal_stat == (cal_year < YearW'(FatBaseYear)), "fat_status disagrees with year")

	// Pre-1980 word is zero
	`E2C_ASSERT(a_fat_zero, cal_valid && cal_stat, cal_fat == '0, "fat_word not zero before 1980")

	// Packed word matches the calendar fields
	`E2C_ASSERT(a_fat_pack, cal_valid && !cal_stat, cal_fat[31:25] == 7'(cal_year - YearW'(FatBaseYear)) && cal_fat[24:21] == cal_month && cal_fat[20:16] == cal_day && cal_fat[15:11] == cal_hour && cal_fat[10:5] == cal_min && cal_fat[4:0] == cal_sec[5:1], "fat_word fields mismatch")

endmodule

bind epoch_seconds_to_calendar_and_fat_top e2c_checker u_e2c_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cal_valid (cal.valid),
	.cal_ready (cal.ready),
	.cal_sec   (cal.second_of_minute),
	.cal_min   (cal.minute_of_hour),
	.cal_hour  (cal.hour_of_day),
	.cal_day   (cal.day_of_month),
	.cal_month (cal.month_of_year),
	.cal_year  (cal.calendar_year),
	.cal_fat   (cal.fat_word),
	.cal_stat  (cal.fat_status)
);

/* dv/e2c_calendar_checker.sv */
// Checker for the epoch-to-calendar block: predicts each result and compares the fields.
`timescale 1ns / 1ps

module e2c_calendar_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ts_valid,
	input  logic                      ts_ready,
	input  logic [e2c_pkg::EpochW-1:0] epoch_seconds,
	input  logic                      cal_valid,
	input  logic                      cal_ready,
	input  logic [e2c_pkg::SecW-1:0]  second_of_minute,
	input  logic [e2c_pkg::MinW-1:0]  minute_of_hour,
	input  logic [e2c_pkg::HourW-1:0] hour_of_day,
	input  logic [e2c_pkg::DayW-1:0]  day_of_month,
	input  logic [e2c_pkg::MonW-1:0]  month_of_year,
	input  logic [e2c_pkg::YearW-1:0] calendar_year,
	input  logic [e2c_pkg::FatW-1:0]  fat_word,
	input  logic                      fat_status,
	output int                        fail_count,
	output int                        outstanding,
	output int                        checked,
	output int                        pre_fat_seen
);
	import e2c_pkg::*;

	typedef struct packed {
		logic [SecW-1:0]  sec;
		logic [MinW-1:0]  min;
		logic [HourW-1:0] hour;
		logic [DayW-1:0]  day;
		logic [MonW-1:0]  mon;
		logic [YearW-1:0] year;
		logic [FatW-1:0]  fat;
		logic             pre_fat;
	} cal_t;

	cal_t due_results[$];

	// Calendar split on 1461-day cycles, third year of each cycle leap (2100 included).
	function automatic cal_t calendar_of(input logic [EpochW-1:0] stamp);
		int unsigned rest;
		int unsigned days;
		int unsigned doy;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		logic        leap;
		cal_t        r;
		rest = stamp;
		r.sec = SecW'(rest % 60);
		rest = rest / 60;
		r.min = MinW'(rest % 60);
		rest = rest / 60;
		r.hour = HourW'(rest % 24);
		days = rest / 24;
		doy = days % DaysPerCycle;
		yr = BaseYear + 4 * (days / DaysPerCycle);
		leap = 1'b0;
		if (doy >= YearLen) begin
			doy -= YearLen;
			yr++;
			if (doy >= YearLen) begin
				doy -= YearLen;
				yr++;
				if (doy < LeapLen) begin
					leap = 1'b1;
				end else begin
					doy -= LeapLen;
					yr++;
				end
			end
		end
		mon = 1;
		forever begin
			case (mon)
				2:           mlen = leap ? 29 : 28;
				4, 6, 9, 11: mlen = 30;
				default:     mlen = 31;
			endcase
			if (doy < mlen || mon == 12) break;
			doy -= mlen;
			mon++;
		end
		r.day = DayW'(doy + 1);
		r.mon = MonW'(mon);
		r.year = YearW'(yr);
		if (yr < FatBaseYear) begin
			r.fat = '0;
			r.pre_fat = 1'b1;
		end else begin
			r.fat = {7'(yr - FatBaseYear), r.mon, r.day, r.hour, r.min, 5'(r.sec >> 1)};
			r.pre_fat = 1'b0;
		end
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
				$time, fname, exp_v, exp_v, act_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		cal_t want;
		if (!arst_n) begin
			due_results.delete();
			fail_count = 0;
			outstanding = 0;
			checked = 0;
			pre_fat_seen = 0;
		end else begin
			if (ts_valid && ts_ready) begin
				due_results.push_back(calendar_of(epoch_seconds));
			end
			if (cal_valid && cal_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result transfer, expected none, actual fat 0x%08h",
						$time, fat_word);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("second_of_minute", want.sec, second_of_minute);
					check_field("minute_of_hour", want.min, minute_of_hour);
					check_field("hour_of_day", want.hour, hour_of_day);
					check_field("day_of_month", want.day, day_of_month);
					check_field("month_of_year", want.mon, month_of_year);
					check_field("calendar_year", want.year, calendar_year);
					check_field("fat_word", want.fat, fat_word);
					check_field("fat_status", want.pre_fat, fat_status);
					checked++;
					if (want.pre_fat) pre_fat_seen++;
				end
			end
			outstanding = due_results.size();
		end
	end

endmodule

/* dv/tb_epoch_seconds_to_calendar_and_fat_top.sv */
// Top of the epoch-to-calendar testbench: clock, reset, timestamp stimulus and verdict.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_and_fat_top;
	import e2c_pkg::*;

	localparam int RandomStamps  = 750;
	localparam int IdlePct       = 19;
	localparam int SteadyFirst   = 300;   // no idling on either side from here ...
	localparam int SteadyLast    = 420;   // ... up to here
	localparam int HoldAt        = 150;   // transfer count that triggers the long hold-off
	localparam int HoldCycles    = 80;
	localparam int DrainCycles   = 30;
	localparam int SecsPerDay    = 86400;
	localparam int unsigned LastDay = 49709;   // last whole day below 2^32 seconds
	localparam int unsigned Fat1980 = 315532800;

	logic clk;
	logic arst_n;

	e2c_epoch_if ts_ch();
	e2c_cal_if   cal_ch();

	epoch_seconds_to_calendar_and_fat_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.ts    (ts_ch),
		.cal   (cal_ch)
	);

	int fail_count;
	int outstanding;
	int checked;
	int pre_fat_seen;

	e2c_calendar_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.ts_valid        (ts_ch.valid),
		.ts_ready        (ts_ch.ready),
		.epoch_seconds   (ts_ch.epoch_seconds),
		.cal_valid       (cal_ch.valid),
		.cal_ready       (cal_ch.ready),
		.second_of_minute(cal_ch.second_of_minute),
		.minute_of_hour  (cal_ch.minute_of_hour),
		.hour_of_day     (cal_ch.hour_of_day),
		.day_of_month    (cal_ch.day_of_month),
		.month_of_year   (cal_ch.month_of_year),
		.calendar_year   (cal_ch.calendar_year),
		.fat_word        (cal_ch.fat_word),
		.fat_status      (cal_ch.fat_status),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.checked         (checked),
		.pre_fat_seen    (pre_fat_seen)
	);

	// transfers accepted on the timestamp channel so far
	int sent = 0;
	// percent of idle cycles on both sides; dropped to 0 for the steady stretch
	int idle_pct = IdlePct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timestamp built from a day count since 1970-01-01 and a time of day.
	function automatic logic [EpochW-1:0] epoch_of(input int unsigned days, input int unsigned h,
		input int unsigned m, input int unsigned s);
		longint unsigned total;
		total = longint'(days) * SecsPerDay + h * 3600 + m * 60 + s;
		return EpochW'(total);
	endfunction

	// Random timestamp, weighted toward day edges, pre-1980 dates and the top of the range.
	function automatic logic [EpochW-1:0] random_stamp();
		logic [EpochW-1:0] stamp;
		case ($urandom_range(5))
			0, 1: stamp = $urandom;
			2:    stamp = $urandom_range(Fat1980 - 1);
			3:    stamp = epoch_of($urandom_range(LastDay), $urandom_range(1) ? 23 : 0,
					$urandom_range(1) ? 59 : 0, $urandom_range(59));
			4:    stamp = epoch_of($urandom_range(LastDay, 46000), $urandom_range(23),
					$urandom_range(59), $urandom_range(59));
			default: stamp = 32'hFFFF_FFFF - $urandom_range(4000000);
		endcase
		return stamp;
	endfunction

	// Offer one timestamp after a random gap and hold it until the block takes it.
	task automatic offer_stamp(input logic [EpochW-1:0] stamp);
		while ($urandom_range(99) < idle_pct) begin
			ts_ch.valid <= 1'b0;
			@(posedge clk);
		end
		ts_ch.valid <= 1'b1;
		ts_ch.epoch_seconds <= stamp;
		@(posedge clk);
		while (!ts_ch.ready) @(posedge clk);
		sent++;
	endtask

	// Reset is applied once, at the start.
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Result side: random back-pressure, one long hold-off, none in the steady stretch.
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		cal_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				cal_ch.ready <= 1'b0;
				hold_left--;
			end else if (!held && sent >= HoldAt) begin
				// the pipeline fills up and ts.ready has to drop while the sender keeps offering
				held = 1'b1;
				hold_left = HoldCycles - 1;
				cal_ch.ready <= 1'b0;
			end else begin
				cal_ch.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		logic [EpochW-1:0] corner_stamps[$];
		ts_ch.valid <= 1'b0;
		ts_ch.epoch_seconds <= '0;
		corner_stamps = '{
			32'd0,                          // epoch start
			32'hFFFF_FFFF,                  // top of range, year 2106
			32'd59, 32'd60,                 // minute carry
			32'd3599, 32'd3600,             // hour carry
			32'd86399, 32'd86400,           // day carry
			epoch_of(364, 23, 59, 59),      // last second of 1970
			epoch_of(789, 12, 0, 1),        // leap day 1972
			epoch_of(1095, 23, 59, 59),     // day 366 of leap year 1972
			epoch_of(1096, 0, 0, 0),        // 1973 begins
			Fat1980 - 1,                    // last second without a FAT word
			Fat1980,                        // first FAT-encodable second
			Fat1980 + 1,                    // odd second, halved in FAT
			epoch_of(47541, 23, 59, 59),    // Feb 29 2100 under the four-year rule
			epoch_of(47542, 0, 0, 0),       // Mar 1 2100, off by a day from Gregorian
			32'h7FFF_FFFF, 32'h8000_0000,
			32'hAAAA_AAAA, 32'h5555_5555
		};
		@(posedge arst_n);
		@(posedge clk);
		foreach (corner_stamps[i]) offer_stamp(corner_stamps[i]);
		for (int n = 0; n < RandomStamps; n++) begin
			idle_pct = (n >= SteadyFirst && n < SteadyLast) ? 0 : IdlePct;
			offer_stamp(random_stamp());
		end
		ts_ch.valid <= 1'b0;
		// let the checker record the last transfer, then drain
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("Summary: %0d timestamps sent, %0d results checked, %0d of them before 1980",
			sent, checked, pre_fat_seen);
		$display("Summary: one %0d-cycle result hold-off and a %0d-item stretch without idling",
			HoldCycles, SteadyLast - SteadyFirst);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#5ms;
		$display("Timeout after %0t with %0d results outstanding", $time, outstanding);
		$display("Verification failed");
		$finish;
	end

endmodule
